// File: sv/aabbcet_pkg.sv
// ----------------------------------------------------------------------------
// aabbcet_pkg
// types and constants shared by the contact event tracker
// ----------------------------------------------------------------------------
package aabbcet_pkg;

   localparam int ID_WIDTH    = 6;
   localparam int LAYER_WIDTH = 3;
   localparam int POS_WIDTH   = 24;
   localparam int SIZE_WIDTH  = 16;
   localparam int ENABLE_BITS = 64;

   typedef enum logic [1:0] {
      EVENT_NONE  = 2'd0,
      EVENT_ENTER = 2'd1,
      EVENT_STAY  = 2'd2,
      EVENT_EXIT  = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]           left_id;
      logic [ID_WIDTH-1:0]           right_id;
      logic [LAYER_WIDTH-1:0]        left_layer;
      logic [LAYER_WIDTH-1:0]        right_layer;
      logic signed [POS_WIDTH-1:0]   left_x;
      logic signed [POS_WIDTH-1:0]   left_y;
      logic signed [POS_WIDTH-1:0]   right_x;
      logic signed [POS_WIDTH-1:0]   right_y;
      logic signed [SIZE_WIDTH-1:0]  left_w;
      logic signed [SIZE_WIDTH-1:0]  left_h;
      logic signed [SIZE_WIDTH-1:0]  right_w;
      logic signed [SIZE_WIDTH-1:0]  right_h;
   } req_type;

   typedef struct packed {
      event_kind_type       event_kind;
      logic [ID_WIDTH-1:0]  out_left_id;
      logic [ID_WIDTH-1:0]  out_right_id;
   } rsp_type;

endpackage

// File: sv/aabb_contact_event_tracker.sv
// ----------------------------------------------------------------------------
// aabb_contact_event_tracker
// box overlap test per collider pair with enter / stay / exit tracking
// ----------------------------------------------------------------------------
//  channel  | ports                          | transfer when
//  ---------+--------------------------------+---------------------------
//  request  | req_valid req_stall req_data   | req_valid && !req_stall
//  response | rsp_valid rsp_stall rsp_data   | rsp_valid && !rsp_stall
//  csr      | csr_wr_en csr_wr_data          | csr_wr_en
//
// one pair per cycle sustained unless rsp_stall or the clearing pass holds
// the pipe; a request is registered in stage 1 (s1_*), then in the response
// register. the touching bits live in one row-wide memory (one row per
// left id) with one read and one write each cycle; a write to the row being
// read in the same cycle is forwarded. after reset a clearing pass zeroes
// one row a cycle over min(MAX_COLLIDERS, 64) rows with req_stall high; a
// stalled response holds the pipe and raises req_stall.
module aabb_contact_event_tracker
   import aabbcet_pkg::*;
#(
   parameter int MAX_COLLIDERS = 64,
   parameter int NUM_LAYERS    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [ENABLE_BITS-1:0] csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   localparam int ID_RANGE = 1 << ID_WIDTH;
   localparam int ID_SPAN  = (MAX_COLLIDERS < ID_RANGE) ? MAX_COLLIDERS : ID_RANGE;
   localparam int ROW_BITS = $clog2(ID_SPAN);
   localparam logic [ID_WIDTH:0]    ID_LIMIT    = (ID_WIDTH+1)'(ID_SPAN);
   localparam logic [LAYER_WIDTH:0] LAYER_LIMIT = (LAYER_WIDTH+1)'(NUM_LAYERS);
   localparam logic [ROW_BITS-1:0]  LAST_ROW    = ROW_BITS'(ID_SPAN - 1);

   // touching bits, row = left id, column = right id
   logic [ID_SPAN-1:0] touch_mem [ID_SPAN];

   logic [ENABLE_BITS-1:0] enable_ff;
   logic                   clearing_ff;
   logic [ROW_BITS-1:0]    clear_row_ff;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_elig_ff;
   logic                   s1_fwd_ff;
   logic [ID_WIDTH-1:0]    s1_lid_ff, s1_rid_ff;
   logic [POS_WIDTH:0]     s1_dx_abs_ff, s1_dy_abs_ff;
   logic signed [SIZE_WIDTH:0] s1_sw_ff, s1_sh_ff;
   logic [ID_SPAN-1:0]     rd_row_ff;
   logic [ID_SPAN-1:0]     fwd_row_ff;

   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   // request side
   logic                   accept;
   logic                   s1_go;
   logic [LAYER_WIDTH-1:0] layer_lo, layer_hi;
   logic [5:0]             enable_idx;
   logic                   eligible;
   logic signed [POS_WIDTH:0]  dx, dy;
   logic [POS_WIDTH:0]     dx_abs, dy_abs;
   logic signed [SIZE_WIDTH:0] sw, sh;

   // update side
   logic [ID_SPAN-1:0]     cur_row, new_row;
   logic                   touching, hit;
   logic signed [21:0]     span_w, span_h, sw_ext, sh_ext;
   logic [21:0]            span_w_abs, span_h_abs;
   event_kind_type         event_kind;
   logic                   s1_write;
   logic                   wr_en;
   logic [ROW_BITS-1:0]    wr_addr;
   logic [ID_SPAN-1:0]     wr_row;

   assign s1_go     = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clearing_ff || (s1_valid_ff && !s1_go);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (req_data.left_layer < req_data.right_layer) begin
         layer_lo = req_data.left_layer;
         layer_hi = req_data.right_layer;
      end else begin
         layer_lo = req_data.right_layer;
         layer_hi = req_data.left_layer;
      end
      enable_idx = {3'd0, layer_lo} * {2'd0, LAYER_LIMIT} + {3'd0, layer_hi};
      eligible = ({1'b0, layer_hi} < LAYER_LIMIT)
               && (req_data.left_id != req_data.right_id)
               && ({1'b0, req_data.left_id} < ID_LIMIT)
               && ({1'b0, req_data.right_id} < ID_LIMIT)
               && enable_ff[enable_idx];
      dx = {req_data.left_x[POS_WIDTH-1], req_data.left_x}
         - {req_data.right_x[POS_WIDTH-1], req_data.right_x};
      dy = {req_data.left_y[POS_WIDTH-1], req_data.left_y}
         - {req_data.right_y[POS_WIDTH-1], req_data.right_y};
      dx_abs = dx[POS_WIDTH] ? -dx : dx;
      dy_abs = dy[POS_WIDTH] ? -dy : dy;
      sw = {req_data.left_w[SIZE_WIDTH-1], req_data.left_w}
         + {req_data.right_w[SIZE_WIDTH-1], req_data.right_w};
      sh = {req_data.left_h[SIZE_WIDTH-1], req_data.left_h}
         + {req_data.right_h[SIZE_WIDTH-1], req_data.right_h};
   end

   always_comb begin
      cur_row  = s1_fwd_ff ? fwd_row_ff : rd_row_ff;
      touching = cur_row[s1_rid_ff[ROW_BITS-1:0]];
      // 25 * size as 16s + 8s + s
      sw_ext = {{5{s1_sw_ff[SIZE_WIDTH]}}, s1_sw_ff};
      sh_ext = {{5{s1_sh_ff[SIZE_WIDTH]}}, s1_sh_ff};
      span_w = (sw_ext <<< 4) + (sw_ext <<< 3) + sw_ext;
      span_h = (sh_ext <<< 4) + (sh_ext <<< 3) + sh_ext;
      span_w_abs = span_w[21] ? -span_w : span_w;
      span_h_abs = span_h[21] ? -span_h : span_h;
      hit = (s1_dx_abs_ff < {3'd0, span_w_abs}) && (s1_dy_abs_ff < {3'd0, span_h_abs});
      new_row = cur_row;
      new_row[s1_rid_ff[ROW_BITS-1:0]] = hit;
      if (!s1_elig_ff) begin
         event_kind = EVENT_NONE;
      end else if (hit) begin
         event_kind = touching ? EVENT_STAY : EVENT_ENTER;
      end else begin
         event_kind = touching ? EVENT_EXIT : EVENT_NONE;
      end
   end

   assign s1_write = s1_valid_ff && s1_go && s1_elig_ff;
   assign wr_en    = clearing_ff || s1_write;
   assign wr_addr  = clearing_ff ? clear_row_ff : s1_lid_ff[ROW_BITS-1:0];
   assign wr_row   = clearing_ff ? '0 : new_row;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         touch_mem[wr_addr] <= wr_row;
      end
      if (accept) begin
         rd_row_ff <= touch_mem[req_data.left_id[ROW_BITS-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         clearing_ff  <= 1'b1;
         clear_row_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         if (clearing_ff) begin
            if (clear_row_ff == LAST_ROW) begin
               clearing_ff <= 1'b0;
            end
            clear_row_ff <= clear_row_ff + 1'b1;
         end
         s1_valid_ff <= s1_valid_in;
         if (s1_valid_ff && s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_elig_ff   <= eligible;
         s1_lid_ff    <= req_data.left_id;
         s1_rid_ff    <= req_data.right_id;
         s1_dx_abs_ff <= dx_abs;
         s1_dy_abs_ff <= dy_abs;
         s1_sw_ff     <= sw;
         s1_sh_ff     <= sh;
         // row written this cycle is the one being read: memory returns old data
         s1_fwd_ff    <= s1_write && (wr_addr == req_data.left_id[ROW_BITS-1:0]);
         fwd_row_ff   <= wr_row;
      end
      if (s1_valid_ff && s1_go) begin
         rsp_data_ff.event_kind   <= event_kind;
         rsp_data_ff.out_left_id  <= s1_lid_ff;
         rsp_data_ff.out_right_id <= s1_rid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sim/aabb_contact_event_tracker_tb.sv
// ----------------------------------------------------------------------------
// aabb_contact_event_tracker_tb
// self-checking bench for the box contact tracker: a local predictor keeps
// its own layer matrix and touching bits, each response transfer is compared
// with the oldest prediction, and directed cases are followed by random
// contact sequences under several layer matrices, most with random stalls
// ----------------------------------------------------------------------------
module aabb_contact_event_tracker_tb;
   import aabbcet_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LAYERS   = 8;
   localparam int PAIR_IDS = 64;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [ENABLE_BITS-1:0] csr_wr_data = '0;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_data;

   // predictor state
   logic [ENABLE_BITS-1:0] layer_matrix = '0;
   bit                     touching [PAIR_IDS*PAIR_IDS];
   rsp_type                pending_events [$];
   int                     mismatches = 0;

   // idling controls
   bit gaps_on  = 1'b0;
   bit stall_on = 1'b0;
   int stall_left = 0;

   // random contact scenario
   logic [ID_WIDTH-1:0]    id_pool [4];
   logic [LAYER_WIDTH-1:0] layer_of [PAIR_IDS];

   aabb_contact_event_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic longint span_abs(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // works out the event of one pair and updates the touching bit
   function automatic rsp_type predict_contact(input req_type p);
      rsp_type r;
      int      lo, hi, idx;
      longint  dx, dy, sx, sy;
      bit      hit;
      r.event_kind   = EVENT_NONE;
      r.out_left_id  = p.left_id;
      r.out_right_id = p.right_id;
      lo = (p.left_layer < p.right_layer) ? int'(p.left_layer) : int'(p.right_layer);
      hi = (p.left_layer < p.right_layer) ? int'(p.right_layer) : int'(p.left_layer);
      if (p.left_id != p.right_id && layer_matrix[lo*LAYERS + hi]) begin
         dx = longint'($signed(p.left_x)) - longint'($signed(p.right_x));
         dy = longint'($signed(p.left_y)) - longint'($signed(p.right_y));
         sx = 25 * (longint'($signed(p.left_w)) + longint'($signed(p.right_w)));
         sy = 25 * (longint'($signed(p.left_h)) + longint'($signed(p.right_h)));
         hit = (span_abs(dx) < span_abs(sx)) && (span_abs(dy) < span_abs(sy));
         idx = int'(p.left_id) * PAIR_IDS + int'(p.right_id);
         if (hit) begin
            r.event_kind = touching[idx] ? EVENT_STAY : EVENT_ENTER;
            touching[idx] = 1'b1;
         end else if (touching[idx]) begin
            r.event_kind = EVENT_EXIT;
            touching[idx] = 1'b0;
         end
      end
      return r;
   endfunction

   // response check and prediction on every request transfer
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               $error("response with nothing outstanding: left_id %0d right_id %0d",
                      rsp_data.out_left_id, rsp_data.out_right_id);
               mismatches++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_data.event_kind != want.event_kind) begin
                  $error("event_kind: expected %0d, got %0d",
                         want.event_kind, rsp_data.event_kind);
                  mismatches++;
               end
               if (rsp_data.out_left_id != want.out_left_id) begin
                  $error("out_left_id: expected %0d, got %0d",
                         want.out_left_id, rsp_data.out_left_id);
                  mismatches++;
               end
               if (rsp_data.out_right_id != want.out_right_id) begin
                  $error("out_right_id: expected %0d, got %0d",
                         want.out_right_id, rsp_data.out_right_id);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_events.push_back(predict_contact(req_data));
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_on && $urandom_range(0, 3) == 0)
            stall_left <= idle_length();
      end
   end

   task automatic send_pair(input req_type item);
      int gap;
      gap = gaps_on ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_layer_matrix(input logic [ENABLE_BITS-1:0] value);
      wait_for_quiet();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      layer_matrix  = value;
   endtask

   function automatic req_type build_pair(input int lid, input int rid,
                                          input int ll, input int rl,
                                          input int lx, input int ly,
                                          input int rx, input int ry,
                                          input int lw, input int lh,
                                          input int rw, input int rh);
      req_type p;
      p.left_id     = ID_WIDTH'(lid);
      p.right_id    = ID_WIDTH'(rid);
      p.left_layer  = LAYER_WIDTH'(ll);
      p.right_layer = LAYER_WIDTH'(rl);
      p.left_x      = POS_WIDTH'(lx);
      p.left_y      = POS_WIDTH'(ly);
      p.right_x     = POS_WIDTH'(rx);
      p.right_y     = POS_WIDTH'(ry);
      p.left_w      = SIZE_WIDTH'(lw);
      p.left_h      = SIZE_WIDTH'(lh);
      p.right_w     = SIZE_WIDTH'(rw);
      p.right_h     = SIZE_WIDTH'(rh);
      return p;
   endfunction

   function automatic int size_pick();
      int s;
      s = $urandom_range(0, 600);
      return ($urandom_range(0, 9) == 0) ? -s : s;
   endfunction

   function automatic int offset_pick(input int reach);
      return int'($urandom_range(0, 3*reach + 2)) - (3*reach/2 + 1);
   endfunction

   function automatic req_type random_pair();
      req_type p;
      int      reach_x, reach_y, cx, cy;
      if ($urandom_range(0, 99) < 15) begin
         // unconstrained noise, reaches every field bit
         p.left_id     = ID_WIDTH'($urandom);
         p.right_id    = ID_WIDTH'($urandom);
         p.left_layer  = LAYER_WIDTH'($urandom);
         p.right_layer = LAYER_WIDTH'($urandom);
         p.left_x      = POS_WIDTH'($urandom);
         p.left_y      = POS_WIDTH'($urandom);
         p.right_x     = POS_WIDTH'($urandom);
         p.right_y     = POS_WIDTH'($urandom);
         p.left_w      = SIZE_WIDTH'($urandom);
         p.left_h      = SIZE_WIDTH'($urandom);
         p.right_w     = SIZE_WIDTH'($urandom);
         p.right_h     = SIZE_WIDTH'($urandom);
      end else begin
         p.left_id     = id_pool[$urandom_range(0, 3)];
         p.right_id    = id_pool[$urandom_range(0, 3)];
         p.left_layer  = layer_of[p.left_id];
         p.right_layer = layer_of[p.right_id];
         p.left_w      = SIZE_WIDTH'(size_pick());
         p.left_h      = SIZE_WIDTH'(size_pick());
         p.right_w     = SIZE_WIDTH'(size_pick());
         p.right_h     = SIZE_WIDTH'(size_pick());
         reach_x = 25 * (int'($signed(p.left_w)) + int'($signed(p.right_w)));
         reach_y = 25 * (int'($signed(p.left_h)) + int'($signed(p.right_h)));
         reach_x = (reach_x < 0) ? -reach_x : reach_x;
         reach_y = (reach_y < 0) ? -reach_y : reach_y;
         cx = int'($urandom_range(0, 8000000)) - 4000000;
         cy = int'($urandom_range(0, 8000000)) - 4000000;
         p.left_x  = POS_WIDTH'(cx);
         p.left_y  = POS_WIDTH'(cy);
         p.right_x = POS_WIDTH'(cx + offset_pick(reach_x));
         p.right_y = POS_WIDTH'(cy + offset_pick(reach_y));
      end
      return p;
   endfunction

   // matrix still at its reset value, so an overlapping pair gives none
   task automatic test_disabled_after_reset();
      send_pair(build_pair(1, 2, 3, 5, 0, 0, 100, 100, 256, 256, 256, 256));
   endtask

   task automatic test_event_sequence();
      write_layer_matrix('1);
      send_pair(build_pair(1, 2, 3, 5, 0, 0, 100, 100, 256, 256, 256, 256));
      send_pair(build_pair(1, 2, 3, 5, 50, 0, 100, 100, 256, 256, 256, 256));
      send_pair(build_pair(1, 2, 3, 5, 0, 0, 90000, 100, 256, 256, 256, 256));
      send_pair(build_pair(1, 2, 3, 5, 0, 0, 90000, 100, 256, 256, 256, 256));
      // reverse order is a separate pair
      send_pair(build_pair(2, 1, 5, 3, 0, 0, 100, 100, 256, 256, 256, 256));
      send_pair(build_pair(5, 5, 1, 1, 0, 0, 0, 0, 256, 256, 256, 256));
      // x overlaps, y does not
      send_pair(build_pair(2, 1, 5, 3, 0, 0, 100, 90000, 256, 256, 256, 256));
   endtask

   task automatic test_size_and_position_extremes();
      send_pair(build_pair(63, 0, 7, 0, 8388607, 8388607, -8388608, -8388608,
                           32767, 32767, 32767, 32767));
      send_pair(build_pair(63, 0, 7, 0, -8388608, -8388608, -8388608, -8388608,
                           -32768, -32768, -32768, -32768));
      // zero sizes never overlap, even at the same centre
      send_pair(build_pair(63, 0, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0));
      // sizes of opposite sign
      send_pair(build_pair(10, 11, 4, 4, 0, 0, 100, -100, 100, 100, -300, -300));
      // distance equal to the summed half sizes is not a contact
      send_pair(build_pair(10, 11, 4, 4, 0, 0, 12800, 0, 256, 256, 256, 256));
      send_pair(build_pair(10, 11, 4, 4, 0, 0, 12799, -12799, 256, 256, 256, 256));
   endtask

   task automatic test_symmetric_layer_lookup();
      write_layer_matrix(ENABLE_BITS'(1) << (2*LAYERS + 6));
      send_pair(build_pair(20, 21, 6, 2, 0, 0, 10, 10, 256, 256, 256, 256));
      send_pair(build_pair(20, 21, 2, 6, 0, 0, 10, 10, 256, 256, 256, 256));
      send_pair(build_pair(20, 21, 6, 6, 0, 0, 90000, 0, 256, 256, 256, 256));
      send_pair(build_pair(20, 21, 2, 2, 0, 0, 90000, 0, 256, 256, 256, 256));
      send_pair(build_pair(20, 21, 2, 6, 0, 0, 90000, 0, 256, 256, 256, 256));
   endtask

   task automatic test_random_contacts(input logic [ENABLE_BITS-1:0] matrix,
                                       input int count, input bit idling,
                                       input bit pause_midway);
      write_layer_matrix(matrix);
      gaps_on  = idling;
      stall_on = idling;
      foreach (id_pool[i]) id_pool[i] = ID_WIDTH'($urandom);
      foreach (layer_of[i]) layer_of[i] = LAYER_WIDTH'($urandom);
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count/2)
            wait_for_quiet();
         send_pair(random_pair());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // let the clearing pass finish
      do @(posedge clock); while (req_stall);

      test_disabled_after_reset();
      test_event_sequence();
      test_size_and_position_extremes();
      test_symmetric_layer_lookup();

      test_random_contacts('1, 160, 1'b1, 1'b0);
      test_random_contacts({$urandom, $urandom}, 120, 1'b0, 1'b0);
      test_random_contacts('1, 150, 1'b1, 1'b1);
      test_random_contacts({$urandom, $urandom} & {$urandom, $urandom}, 100, 1'b1, 1'b0);
      test_random_contacts('0, 20, 1'b1, 1'b0);
      test_random_contacts('1, 100, 1'b1, 1'b0);

      wait_for_quiet();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: aabb_contact_event_tracker.f
sv/aabbcet_pkg.sv
sv/aabb_contact_event_tracker.sv
sim/aabb_contact_event_tracker_tb.sv
